// ===== sv/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window minimum
// Sizes of the candidate row, cell state and control structs, and the
// window length clamp.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned WINDOW_MAX   = 64;
  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned AGE_W        = $clog2(WINDOW_MAX + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [AGE_W-1:0]               age_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  typedef struct packed {
    logic    valid;
    sample_t value;
    age_t    age;
  } cell_t;

  typedef struct packed {
    logic    clear;
    logic    shift;
    logic    append;
    sample_t sample;
  } cell_ctrl_t;

  // Clamp the programmed window length to 1..WINDOW_MAX.
  function automatic age_t eff_window(logic [CFG_W-1:0] ws);
    age_t w;
    if (ws == '0) begin
      w = AGE_W'(1);
    end else if (32'(ws) > WINDOW_MAX) begin
      w = AGE_W'(WINDOW_MAX);
    end else begin
      w = AGE_W'(ws);
    end
    return w;
  endfunction

endpackage

// ===== sv/swm_if.sv =====
// ----------------------------------------------------------------------------
// swm_if: channel interfaces of the sliding window minimum
// Sample input, result output and window length write channel.
// ----------------------------------------------------------------------------
interface swm_in_if;
  logic              valid;
  logic              ready;
  swm_pkg::sample_t  sample;
  logic              frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface swm_out_if;
  logic              valid;
  logic              ready;
  swm_pkg::sample_t  window_min;

  modport source (output valid, output window_min, input ready);
  modport sink   (input valid, input window_min, output ready);
endinterface

interface swm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swm_pkg::CFG_W-1:0]      window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

// ===== sv/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell: one candidate slot of the monotonic row
// Holds a value and its age; drops itself when larger than the new sample,
// takes the new sample when it is the first free slot, or takes its right
// neighbor on a shift; a clear empties it.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swm_pkg::cell_ctrl_t ctrl_i,
  input  swm_pkg::cell_t      right_i,
  input  logic                prev_stay_i,
  output swm_pkg::cell_t      cell_o,
  output logic                stay_o
);

  logic             valid_q, valid_d;
  swm_pkg::sample_t value_q, value_d;
  swm_pkg::age_t    age_q, age_d;
  logic             greater;

  assign greater = valid_q && (value_q > ctrl_i.sample);
  assign stay_o  = valid_q && !greater;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    age_d   = age_q;
    priority if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
      age_d   = right_i.age;
    end else if (ctrl_i.append) begin
      if (stay_o) begin
        age_d = age_q + swm_pkg::AGE_W'(1);
      end else if (prev_stay_i) begin
        valid_d = 1'b1;
        value_d = ctrl_i.sample;
        age_d   = swm_pkg::AGE_W'(1);
      end else begin
        valid_d = 1'b0;
      end
    end else begin
      // hold
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

  assign cell_o = '{valid: valid_q, value: value_q, age: age_q};

endmodule

// ===== sv/sliding_window_minimum.sv =====
// Flow: a result is registered when its sample is appended, which waits for each
//   candidate that leaves the window (at most one with a fixed window) and
//   for a free output. A new sample is taken only after the last one is
//   appended; the candidate row shifts one place per cycle to retire old entries.
// Reset: row empty, frame count zero, window length 1, no result pending.
// ----------------------------------------------------------------------------
// sliding_window_minimum: streaming minimum over the last window_size samples
// Monotonic candidate row built from a chain of swm_cell slots, front at 0.
// ----------------------------------------------------------------------------
module sliding_window_minimum (
  input  logic             clk_i,
  input  logic             rst_ni,
  swm_in_if.sink           in_i,
  swm_out_if.source        out_o,
  swm_cfg_if.sink          cfg_i
);

  swm_pkg::state_e     state_q, state_d;
  logic [swm_pkg::CFG_W-1:0] window_size_q;
  swm_pkg::age_t       fill_q, fill_d, fill_inc, win;
  swm_pkg::sample_t    sample_q;
  logic                out_valid_q, out_valid_d;
  swm_pkg::sample_t    out_min_q, out_min_d;
  swm_pkg::cell_ctrl_t ctrl;
  swm_pkg::cell_t      cells [swm_pkg::WINDOW_MAX];
  logic                stays [swm_pkg::WINDOW_MAX];
  logic                in_xfer, expire, do_append, out_free;
  swm_pkg::sample_t    front;

  assign win      = swm_pkg::eff_window(window_size_q);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign expire   = (state_q == swm_pkg::ST_BUSY) && cells[0].valid &&
                    (cells[0].age >= win);
  assign do_append = (state_q == swm_pkg::ST_BUSY) && !expire && out_free;
  assign front    = stays[0] ? cells[0].value : sample_q;

  assign in_i.ready  = (state_q == swm_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.window_min = out_min_q;

  assign ctrl = '{clear:  in_xfer && in_i.frame_start,
                  shift:  expire,
                  append: do_append,
                  sample: sample_q};

  for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .right_i     ((i == swm_pkg::WINDOW_MAX - 1) ? swm_pkg::cell_t'('0) :
                    cells[(i + 1) % swm_pkg::WINDOW_MAX]),
      .prev_stay_i ((i == 0) ? 1'b1 :
                    stays[(i + swm_pkg::WINDOW_MAX - 1) % swm_pkg::WINDOW_MAX]),
      .cell_o      (cells[i]),
      .stay_o      (stays[i])
    );
  end

  assign fill_inc = (32'(fill_q) < swm_pkg::WINDOW_MAX) ? fill_q + swm_pkg::AGE_W'(1) : fill_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_min_d   = out_min_q;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = swm_pkg::ST_BUSY;
          if (in_i.frame_start) begin
            fill_d = '0;
          end
        end
      end
      swm_pkg::ST_BUSY: begin
        if (do_append) begin
          state_d = swm_pkg::ST_IDLE;
          fill_d  = fill_inc;
          if (fill_inc >= win) begin
            out_valid_d = 1'b1;
            out_min_d   = front;
          end
        end
      end
      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= swm_pkg::ST_IDLE;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
      window_size_q <= swm_pkg::CFG_W'(1);
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        window_size_q <= cfg_i.window_size;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_min_q <= out_min_d;
    if (in_xfer) begin
      sample_q <= in_i.sample;
    end
  end

endmodule

// ===== sv/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker: port-level checks for the sliding window minimum
// Watches the channel handshakes of the top level over time.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input swm_pkg::sample_t out_min_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_min_i))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while previous one in flight");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a sample in flight");

endmodule

bind sliding_window_minimum swm_checker u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_min_i   (out_o.window_min)
);

// ===== test/sliding_window_minimum_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimum_tb: self-checking bench for the sliding window minimum
// Streams framed signed samples through the block under several window
// lengths and stall patterns. A tracker keeps its own candidate row and
// checks every result against the minimum it predicts.
// ----------------------------------------------------------------------------
module sliding_window_minimum_tb;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_ITEMS    = 40;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned REPORT_MAX    = 10;

  localparam swm_pkg::sample_t SAMPLE_MIN = {1'b1, {(swm_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam swm_pkg::sample_t SAMPLE_MAX = {1'b0, {(swm_pkg::SAMPLE_WIDTH-1){1'b1}}};

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_RISE,
    SHAPE_FALL,
    SHAPE_FLAT,
    SHAPE_NARROW
  } shape_e;

  class window_min_tracker;
    swm_pkg::sample_t          row_vals[$];
    logic [15:0]               row_pos[$];
    logic [15:0]               next_pos;
    int unsigned               frame_fill;
    logic [swm_pkg::CFG_W-1:0] win_reg;
    swm_pkg::sample_t          expected_mins[$];
    int unsigned               fail_count;
    int unsigned               samples_seen;
    int unsigned               mins_checked;
    int unsigned               windows_written;

    function new();
      win_reg  = swm_pkg::CFG_W'(1);
      next_pos = '0;
      frame_fill = 0;
    endfunction

    static function int unsigned span_of(logic [swm_pkg::CFG_W-1:0] w);
      if (w == '0) begin
        return 1;
      end
      if (int'(w) > swm_pkg::WINDOW_MAX) begin
        return swm_pkg::WINDOW_MAX;
      end
      return int'(w);
    endfunction

    function void set_window(logic [swm_pkg::CFG_W-1:0] w);
      win_reg = w;
      windows_written++;
    endfunction

    function void take_sample(swm_pkg::sample_t s, logic fs);
      int unsigned span;
      logic [15:0] pos;
      logic [15:0] age;
      span = span_of(win_reg);
      samples_seen++;
      if (fs) begin
        row_vals.delete();
        row_pos.delete();
        next_pos = '0;
        frame_fill = 0;
      end
      pos = next_pos;
      while (row_vals.size() > 0) begin
        age = pos - row_pos[0];
        if (age < span) break;
        void'(row_vals.pop_front());
        void'(row_pos.pop_front());
      end
      while (row_vals.size() > 0 && row_vals[$] > s) begin
        void'(row_vals.pop_back());
        void'(row_pos.pop_back());
      end
      if (row_vals.size() >= swm_pkg::WINDOW_MAX) begin
        void'(row_vals.pop_front());
        void'(row_pos.pop_front());
      end
      row_vals.push_back(s);
      row_pos.push_back(pos);
      next_pos = pos + 16'd1;
      if (frame_fill < swm_pkg::WINDOW_MAX) frame_fill++;
      if (frame_fill >= span) expected_mins.push_back(row_vals[0]);
    endfunction

    function void check_min(swm_pkg::sample_t got);
      swm_pkg::sample_t want;
      mins_checked++;
      if (expected_mins.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("window_min %0d arrived with no result outstanding", got);
        return;
      end
      want = expected_mins.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("window_min mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_len;
  int unsigned cycle_count;
  int unsigned random_items;

  window_min_tracker tracker = new();

  swm_in_if  in_ch ();
  swm_out_if out_ch ();
  swm_cfg_if cfg_ch ();

  sliding_window_minimum uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // hold off the receiver while a hold is pending, else stall at random
  always @(posedge clk) begin
    if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.set_window(cfg_ch.window_size);
      if (in_ch.valid && in_ch.ready) tracker.take_sample(in_ch.sample, in_ch.frame_start);
      if (out_ch.valid && out_ch.ready) tracker.check_min(out_ch.window_min);
    end
  end

  function automatic swm_pkg::sample_t rand_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2, 3:    return swm_pkg::sample_t'(int'($urandom_range(8)) - 4);
      default: return swm_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [swm_pkg::CFG_W-1:0] pick_window();
    case ($urandom_range(19))
      0:          return '0;
      1:          return swm_pkg::CFG_W'(swm_pkg::WINDOW_MAX);
      2:          return swm_pkg::CFG_W'($urandom_range(swm_pkg::WINDOW_MAX + 1, 127));
      3, 4, 5:    return swm_pkg::CFG_W'($urandom_range(17, swm_pkg::WINDOW_MAX - 1));
      default:    return swm_pkg::CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send_sample(input swm_pkg::sample_t s, input logic fs);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid       <= 1'b0;
      in_ch.sample      <= swm_pkg::sample_t'($urandom);
      in_ch.frame_start <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.frame_start <= fs;
    // sample ready away from the edge, then advance to the transfer edge
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // drop valid, drain outstanding results, then give the row time to retire
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.expected_mins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] w);
    settle();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned len, input shape_e shape, input logic fresh);
    swm_pkg::sample_t v;
    swm_pkg::sample_t level;
    level = swm_pkg::sample_t'(int'($urandom_range(2000)) - 1000);
    for (int unsigned i = 0; i < len; i++) begin
      case (shape)
        SHAPE_RISE: begin
          level = level + swm_pkg::sample_t'($urandom_range(3));
          v = level;
        end
        SHAPE_FALL: begin
          level = level - swm_pkg::sample_t'($urandom_range(3));
          v = level;
        end
        SHAPE_FLAT:   v = level;
        SHAPE_NARROW: v = swm_pkg::sample_t'(int'($urandom_range(8)) - 4);
        default:      v = rand_sample();
      endcase
      send_sample(v, fresh && (i == 0));
    end
    random_items += len;
  endtask

  initial begin
    logic [swm_pkg::CFG_W-1:0] wreg;
    int unsigned               span;
    int unsigned               len;
    int unsigned               phase_base;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.frame_start  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.window_size = '0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 11;
    recv_idle_pct      = 80;
    hold_len           = 0;
    cycle_count        = 0;
    random_items       = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of one from reset, extremes of the sample range
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(swm_pkg::sample_t'(0), 1'b1);
    send_sample(swm_pkg::sample_t'(-1), 1'b0);
    // zero window acts as one
    write_window('0);
    send_sample(swm_pkg::sample_t'(5), 1'b1);
    send_sample(swm_pkg::sample_t'(-5), 1'b0);
    // short frame, then equal values kept in the row
    write_window(swm_pkg::CFG_W'(3));
    send_sample(swm_pkg::sample_t'(9), 1'b1);
    send_sample(swm_pkg::sample_t'(2), 1'b0);
    send_sample(swm_pkg::sample_t'(5), 1'b1);
    send_sample(swm_pkg::sample_t'(5), 1'b0);
    send_sample(swm_pkg::sample_t'(3), 1'b0);
    send_sample(swm_pkg::sample_t'(7), 1'b0);
    send_sample(swm_pkg::sample_t'(7), 1'b0);
    send_sample(swm_pkg::sample_t'(8), 1'b0);
    // shrink and grow the window in the middle of a frame
    write_window(swm_pkg::CFG_W'(4));
    for (int i = 1; i <= 5; i++) send_sample(swm_pkg::sample_t'(i), i == 1);
    write_window(swm_pkg::CFG_W'(2));
    send_sample(swm_pkg::sample_t'(6), 1'b0);
    send_sample(swm_pkg::sample_t'(7), 1'b0);
    write_window(swm_pkg::CFG_W'(6));
    send_sample(swm_pkg::sample_t'(8), 1'b0);
    // oversized window clamps to the row depth
    write_window('1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 11 : 0;
      if (ph == 2) begin
        // hold the output long enough for the row to back up into the input
        write_window(swm_pkg::CFG_W'(8));
        hold_len = HOLD_CYCLES;
        send_frame(HOLD_ITEMS, SHAPE_RISE, 1'b1);
      end
      phase_base = random_items;
      while (random_items - phase_base < PHASE_ITEMS) begin
        wreg = pick_window();
        write_window(wreg);
        span = window_min_tracker::span_of(wreg);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(4) == 0) len = $urandom_range(1, span);
          else len = span + $urandom_range(0, span + 8);
          send_frame(len, shape_e'($urandom_range(SHAPE_NARROW)), $urandom_range(7) != 0);
        end
      end
    end

    settle();
    $display("Sent %0d samples under %0d window settings; %0d window minima checked",
             tracker.samples_seen, tracker.windows_written, tracker.mins_checked);
    $display("Covered random stalls on both sides, a %0d-cycle output hold and window changes",
             HOLD_CYCLES);
    if (tracker.fail_count == 0 && tracker.expected_mins.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", tracker.fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/swm_pkg.sv
sv/swm_if.sv
sv/swm_cell.sv
sv/sliding_window_minimum.sv
sv/swm_checker.sv
test/sliding_window_minimum_tb.sv
